FILE: rtl/hkp_pkg.sv
`default_nettype none
package hkp_pkg;

    localparam int TABLE_DEPTH_DEF   = 1024;
    localparam int MAX_KEY_BYTES_DEF = 32;

    localparam int BYTE_W     = 8;
    localparam int INDEX_W    = 31;
    localparam int HASH_W     = 64;
    localparam int KEY_W      = 63;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 10;

    localparam logic [HASH_W-1:0] HASH_MULT = 64'd31;
    localparam int SHIFT_R = 21;
    localparam int SHIFT_L = 31;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [INDEX_W-1:0] payload;
    } slot_entry_t;

    function automatic logic [HASH_W-1:0] fold_byte(input logic [HASH_W-1:0] h,
                                                    input logic [BYTE_W-1:0] b);
        logic [HASH_W-1:0] m;
        m = h * HASH_MULT + {{(HASH_W-BYTE_W){1'b0}}, b};
        return m ^ (m >> SHIFT_R) ^ (m << SHIFT_L);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/hkp_hash.sv
`default_nettype none
module hkp_hash import hkp_pkg::*; #(
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              byte_en,
    input  wire logic [BYTE_W-1:0] key_byte,
    input  wire logic              last_byte,
    output logic      [KEY_W-1:0]  key_final
);

    localparam int CNT_W = $clog2(MAX_KEY_BYTES + 1);
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_KEY_BYTES);

    logic [HASH_W-1:0] hash_reg, hash_next, hash_upd;
    logic [CNT_W-1:0]  seen_reg, seen_next;
    logic              do_fold;

    always_comb begin
        do_fold   = seen_reg < MAX_C;
        hash_upd  = do_fold ? fold_byte(hash_reg, key_byte) : hash_reg;
        key_final = hash_upd[KEY_W-1:0];
        hash_next = hash_reg;
        seen_next = seen_reg;
        if (byte_en) begin
            if (last_byte) begin
                hash_next = '0;
                seen_next = '0;
            end else begin
                hash_next = hash_upd;
                seen_next = do_fold ? seen_reg + 1'b1 : seen_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= '0;
            seen_reg <= '0;
        end else begin
            hash_reg <= hash_next;
            seen_reg <= seen_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/hkp_mod.sv
`default_nettype none
module hkp_mod import hkp_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [KEY_W-1:0]               dividend,
    output logic                                done,
    output logic [$clog2(TABLE_DEPTH)-1:0]      remainder
);

    localparam int SLOT_W  = $clog2(TABLE_DEPTH);
    localparam int PROD_W  = 128;
    localparam int SHIFT_Q = KEY_W + SLOT_W;
    localparam logic [PROD_W-1:0] ONE_W    = PROD_W'(1);
    localparam logic [PROD_W-1:0] DEPTH_W  = PROD_W'(TABLE_DEPTH);
    // ceil(2^SHIFT_Q / depth): exact quotient for every 63-bit dividend
    localparam logic [PROD_W-1:0] MAGIC_W  = ((ONE_W << SHIFT_Q) + DEPTH_W - ONE_W) / DEPTH_W;
    localparam logic [63:0]       MAGIC    = MAGIC_W[63:0];
    localparam logic [SLOT_W-1:0] DEPTH_LO = DEPTH_W[SLOT_W-1:0];
    localparam logic [2:0]        STEP_QUOT = 3'd5;
    localparam logic [2:0]        STEP_REM  = 3'd6;

    logic [KEY_W-1:0]    x_reg, x_next;
    logic [63:0]         pp_reg, pp_next;
    logic [1:0]          pp_sh_reg, pp_sh_next;
    logic                pp_vld_reg, pp_vld_next;
    logic [PROD_W-1:0]   acc_reg, acc_next, pp_ext;
    logic [SLOT_W-1:0]   qd_reg, qd_next, rem_reg, rem_next;
    logic [2*SLOT_W-1:0] qd_full;
    logic [31:0]         op_x, op_m;
    logic [2:0]          cnt_reg, cnt_next;
    logic                busy_reg, busy_next, done_reg, done_next;

    // quotient by reciprocal multiplication, one 32x32 partial product per cycle,
    // then remainder from the low bits of quotient times depth
    always_comb begin
        op_x    = cnt_reg[1] ? {1'b0, x_reg[KEY_W-1:32]} : x_reg[31:0];
        op_m    = cnt_reg[0] ? MAGIC[63:32] : MAGIC[31:0];
        pp_ext  = {64'd0, pp_reg} << {pp_sh_reg, 5'd0};
        qd_full = {{SLOT_W{1'b0}}, acc_reg[SHIFT_Q +: SLOT_W]} * {{SLOT_W{1'b0}}, DEPTH_LO};
        x_next      = x_reg;
        pp_next     = pp_reg;
        pp_sh_next  = pp_sh_reg;
        pp_vld_next = 1'b0;
        acc_next    = acc_reg;
        qd_next     = qd_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start) begin
            x_next    = dividend;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (pp_vld_reg) begin
                acc_next = acc_reg + pp_ext;
            end
            if (!cnt_reg[2]) begin
                pp_next     = {32'd0, op_x} * {32'd0, op_m};
                pp_sh_next  = {cnt_reg[1] & cnt_reg[0], cnt_reg[1] ^ cnt_reg[0]};
                pp_vld_next = 1'b1;
            end
            if (cnt_reg == STEP_QUOT) begin
                qd_next = qd_full[SLOT_W-1:0];
            end
            if (cnt_reg == STEP_REM) begin
                rem_next  = x_reg[SLOT_W-1:0] - qd_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
            pp_vld_reg <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
            pp_vld_reg <= pp_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg     <= x_next;
        pp_reg    <= pp_next;
        pp_sh_reg <= pp_sh_next;
        acc_reg   <= acc_next;
        qd_reg    <= qd_next;
        rem_reg   <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

FILE: rtl/hkp_table.sv
`default_nettype none
module hkp_table import hkp_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          rd_en,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0] addr,
    input  wire slot_entry_t                   wdata,
    output slot_entry_t                        rdata
);

    slot_entry_t mem [TABLE_DEPTH];
    slot_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: rtl/hashed_key_linear_probe_insert_top.sv
// Hashes a key streamed in one byte per item (tlast on the final byte) and inserts it into
// an open-addressed table with linear probing, returning status, slot and 63-bit hash for
// each completed key. A final byte is accepted, then passes through the remainder unit (hash
// modulo depth by reciprocal multiplication, its done strobe issuing the first table read),
// one table probe at a time through the single-port table memory, and the result register,
// which is loaded once it is free; a key takes 1 to TABLE_DEPTH probes. After reset a
// clearing pass writes every slot, during which s_tready stays low. A full table without a
// match reports status 2, slot 0.
`default_nettype none
module hashed_key_linear_probe_insert_top import hkp_pkg::*; #(
    parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // key_byte[7:0], entry_index[38:8], zero pad
    input  wire logic        s_tlast,  // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata   // status[1:0], slot[11:2], key_hash[74:12], zero pad
);

    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_MOD    = 5'b00100,
        S_CHECK  = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [SLOT_W-1:0]  pos_reg, pos_next, pos_inc;
    logic [SLOT_W-1:0]  probes_reg, probes_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [INDEX_W-1:0] payload_reg, payload_next;
    status_t            res_status_reg, res_status_next;
    logic [SLOT_W-1:0]  res_slot_reg, res_slot_next;
    logic               m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [SLOT_OUT_W-1:0] m_slot_reg, m_slot_next;
    logic [KEY_W-1:0]      m_key_reg, m_key_next;
    logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

    logic              s_accept;
    logic [KEY_W-1:0]  key_final;
    logic              mod_done;
    logic [SLOT_W-1:0] mod_rem;
    logic              tbl_rd, tbl_wr;
    logic [SLOT_W-1:0] tbl_addr;
    slot_entry_t       tbl_wdata, tbl_rdata;

    assign s_tready = state_reg == S_IDLE;
    assign s_accept = s_tvalid && s_tready;

    hkp_hash #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) u_hash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_en   (s_accept),
        .key_byte  (s_tdata[7:0]),
        .last_byte (s_tlast),
        .key_final (key_final)
    );

    hkp_mod #(.TABLE_DEPTH(TABLE_DEPTH)) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_accept && s_tlast),
        .dividend  (key_final),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    hkp_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
        .aclk  (aclk),
        .rd_en (tbl_rd),
        .wr_en (tbl_wr),
        .addr  (tbl_addr),
        .wdata (tbl_wdata),
        .rdata (tbl_rdata)
    );

    assign pos_inc  = (pos_reg == LAST_SLOT) ? '0 : pos_reg + 1'b1;
    assign slot_ext = {{SLOT_OUT_W{1'b0}}, res_slot_reg};

    always_comb begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        probes_next     = probes_reg;
        key_next        = key_reg;
        payload_next    = payload_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_slot_next     = m_slot_reg;
        m_key_next      = m_key_reg;
        tbl_rd          = 1'b0;
        tbl_wr          = 1'b0;
        tbl_addr        = pos_reg;
        tbl_wdata       = '{valid: 1'b0, key: '0, payload: '0};
        case (state_reg)
            S_CLEAR: begin
                tbl_wr   = 1'b1;
                pos_next = pos_inc;
                if (pos_reg == LAST_SLOT) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept && s_tlast) begin
                    key_next     = key_final;
                    payload_next = s_tdata[38:8];
                    state_next   = S_MOD;
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    tbl_rd      = 1'b1;
                    tbl_addr    = mod_rem;
                    pos_next    = mod_rem;
                    probes_next = '0;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!tbl_rdata.valid) begin
                    tbl_wr          = 1'b1;
                    tbl_wdata       = '{valid: 1'b1, key: key_reg, payload: payload_reg};
                    res_status_next = ST_INSERTED;
                    res_slot_next   = pos_reg;
                    state_next      = S_RESULT;
                end else if (tbl_rdata.key == key_reg) begin
                    res_status_next = ST_PRESENT;
                    res_slot_next   = pos_reg;
                    state_next      = S_RESULT;
                end else if (probes_reg == LAST_SLOT) begin
                    res_status_next = ST_FULL;
                    res_slot_next   = '0;
                    state_next      = S_RESULT;
                end else begin
                    tbl_rd      = 1'b1;
                    tbl_addr    = pos_inc;
                    pos_next    = pos_inc;
                    probes_next = probes_reg + 1'b1;
                end
            end
            S_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_slot_next   = slot_ext[SLOT_OUT_W-1:0];
                    m_key_next    = key_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            pos_reg     <= '0;
            probes_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            probes_reg  <= probes_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg        <= key_next;
        payload_reg    <= payload_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        m_status_reg   <= m_status_next;
        m_slot_reg     <= m_slot_next;
        m_key_reg      <= m_key_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_key_reg, m_slot_reg, m_status_reg};

    a_wr_state: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_wr |-> (state_reg == S_CLEAR || state_reg == S_CHECK))
        else $error("table write outside clear or probe");

    a_mod_done: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_done |-> state_reg == S_MOD)
        else $error("remainder finished outside modulo wait");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_RESULT))
        else $error("result appeared without a completed probe");

    a_full_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == ST_FULL) |-> m_slot_reg == '0)
        else $error("full status with non-zero slot");

endmodule
`default_nettype wire
